// ===== rtl/dataflow_depth_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// Dataflow depth tracker assertion macros
// Shared shorthand for the concurrent checks on the tracker's ports.
// ----------------------------------------------------------------------------
`ifndef DATAFLOW_DEPTH_TRACKER_MACROS_SVH
`define DATAFLOW_DEPTH_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFDT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dataflow depth tracker check failed");

// The consequent must hold in the cycle after the antecedent.
`define DFDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dataflow depth tracker check failed");

`endif

// ===== rtl/dfdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Dataflow depth tracker package
// Field widths, stream packing positions and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package dfdt_pkg;

    localparam int REG_W   = 5;
    localparam int OP_W    = 3;
    localparam int IDX_W   = 12;
    localparam int DEP_W   = 13;
    localparam int DEPTH_W = 20;
    localparam int LAT_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;

    localparam int IN_OP_LSB   = 0;
    localparam int IN_DST_LSB  = IN_OP_LSB + OP_W;
    localparam int IN_SA_LSB   = IN_DST_LSB + REG_W;
    localparam int IN_SB_LSB   = IN_SA_LSB + REG_W;
    localparam int IN_USED_W   = IN_SB_LSB + REG_W;

    localparam int OUT_IDX_LSB   = 0;
    localparam int OUT_DA_LSB    = OUT_IDX_LSB + IDX_W;
    localparam int OUT_DB_LSB    = OUT_DA_LSB + DEP_W;
    localparam int OUT_DEPTH_LSB = OUT_DB_LSB + DEP_W;
    localparam int OUT_PROG_LSB  = OUT_DEPTH_LSB + DEPTH_W;
    localparam int OUT_USED_W    = OUT_PROG_LSB + DEPTH_W;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
    localparam logic [DEP_W-1:0]   DEP_ENTRY = '1;
    localparam logic [LAT_W-1:0]   LAT_RESET = LAT_W'(1);

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [DEPTH_W-1:0] finish;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic             clear;
        logic [REG_W-1:0] dest;
        entry_t           data;
    } tbl_wr_t;

    typedef struct packed {
        logic             first;
        logic [OP_W-1:0]  opcode;
        logic [REG_W-1:0] dest;
        logic [REG_W-1:0] src_a;
        logic [REG_W-1:0] src_b;
    } in_item_t;

endpackage

`default_nettype wire

// ===== rtl/dataflow_depth_tracker.sv =====
// ----------------------------------------------------------------------------
// Dataflow depth tracker
// Critical-path analysis of a streamed instruction trace.
// ----------------------------------------------------------------------------
// The tracker takes one instruction per clock while the output is not stalled
// and returns one result per instruction: the source lookups are read from the
// last-writer memory into the read registers as the request is taken, and the
// depth, latency add and program maximum are then formed from them into the
// output register. A back-to-back dependency on the previous instruction is
// served by a bypass into the read registers. The first_of_program flag
// clears the register tables as its instruction advances. The user writes the
// latency registers via the configuration port while idle; not enforced here.
// ----------------------------------------------------------------------------
`default_nettype none

module dataflow_depth_tracker #(
    parameter int NUM_REGS    = 32,
    parameter int MAX_INSTS   = 4096,
    parameter int NUM_OPCODES = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // opcode, dest_reg, source_a, source_b, zero fill
    input  wire logic [dfdt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // first_of_program
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // inst_index, dep_a, dep_b, inst_depth, prog_depth, zero fill
    output logic [dfdt_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // overflow
    output logic                                     m_axis_tuser,
    input  wire logic                                cfg_we,
    input  wire logic [dfdt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dfdt_pkg::LAT_W-1:0]          cfg_data
);

    localparam int CNT_W = $clog2(MAX_INSTS + 1);
    localparam int LAT_AW = (NUM_OPCODES > 1) ? $clog2(NUM_OPCODES) : 1;

    logic [dfdt_pkg::LAT_W-1:0] lat_reg [NUM_OPCODES];

    logic                s1_valid_reg;
    dfdt_pkg::in_item_t  s1_item_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [dfdt_pkg::DEPTH_W-1:0] pd_reg;
    logic [dfdt_pkg::DEPTH_W-1:0] pd_next;

    logic                              out_valid_reg;
    logic [dfdt_pkg::OUT_TDATA_W-1:0]  out_data_reg;
    logic [dfdt_pkg::OUT_TDATA_W-1:0]  out_data_next;
    logic                              out_ovf_reg;

    dfdt_pkg::in_item_t in_item;
    dfdt_pkg::tbl_wr_t  wr;
    dfdt_pkg::entry_t   rd_a, rd_b;
    logic               hit_a, hit_b;
    logic               accept, s1_adv;

    logic [CNT_W-1:0]             eff_cnt;
    logic [16:0]                  cnt_w;
    logic [dfdt_pkg::DEPTH_W-1:0] eff_pd, ta, tb, depth, finish, new_pd;
    logic [dfdt_pkg::DEPTH_W:0]   sum;
    logic [dfdt_pkg::LAT_W-1:0]   lat;
    logic [dfdt_pkg::DEP_W-1:0]   da, db;
    logic [dfdt_pkg::IDX_W-1:0]   idx;
    logic                         ovf;

    assign in_item.first  = s_axis_tuser;
    assign in_item.opcode = s_axis_tdata[dfdt_pkg::IN_OP_LSB +: dfdt_pkg::OP_W];
    assign in_item.dest   = s_axis_tdata[dfdt_pkg::IN_DST_LSB +: dfdt_pkg::REG_W];
    assign in_item.src_a  = s_axis_tdata[dfdt_pkg::IN_SA_LSB +: dfdt_pkg::REG_W];
    assign in_item.src_b  = s_axis_tdata[dfdt_pkg::IN_SB_LSB +: dfdt_pkg::REG_W];

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_OPCODES; i++)
            begin
                lat_reg[i] <= dfdt_pkg::LAT_RESET;
            end
        end
        else if (cfg_we && (32'(cfg_index) < 32'(NUM_OPCODES)))
        begin
            lat_reg[cfg_index[LAT_AW-1:0]] <= cfg_data;
        end
    end

    always_comb
    begin
        eff_cnt = s1_item_reg.first ? '0 : cnt_reg;
        eff_pd  = s1_item_reg.first ? '0 : pd_reg;
        cnt_w   = 17'(eff_cnt);
        idx     = cnt_w[dfdt_pkg::IDX_W-1:0];
        ovf     = 32'(eff_cnt) >= 32'(MAX_INSTS);

        ta = hit_a ? rd_a.finish : '0;
        tb = hit_b ? rd_b.finish : '0;
        da = hit_a ? {1'b0, rd_a.index} : dfdt_pkg::DEP_ENTRY;
        db = hit_b ? {1'b0, rd_b.index} : dfdt_pkg::DEP_ENTRY;
        depth = (ta >= tb) ? ta : tb;

        lat = (32'(s1_item_reg.opcode) < 32'(NUM_OPCODES))
            ? lat_reg[s1_item_reg.opcode[LAT_AW-1:0]] : '0;
        sum    = {1'b0, depth} + (dfdt_pkg::DEPTH_W + 1)'(lat);
        finish = sum[dfdt_pkg::DEPTH_W] ? dfdt_pkg::DEPTH_MAX : sum[dfdt_pkg::DEPTH_W-1:0];
        new_pd = (finish > eff_pd) ? finish : eff_pd;

        cnt_next = ovf ? eff_cnt : eff_cnt + CNT_W'(1);
        pd_next  = ovf ? eff_pd : new_pd;

        wr.en          = s1_adv && !ovf;
        wr.clear       = s1_adv && s1_item_reg.first;
        wr.dest        = s1_item_reg.dest;
        wr.data.index  = idx;
        wr.data.finish = finish;

        out_data_next = '0;
        out_data_next[dfdt_pkg::OUT_PROG_LSB +: dfdt_pkg::DEPTH_W] = pd_next;
        if (!ovf)
        begin
            out_data_next[dfdt_pkg::OUT_IDX_LSB +: dfdt_pkg::IDX_W]     = idx;
            out_data_next[dfdt_pkg::OUT_DA_LSB +: dfdt_pkg::DEP_W]      = da;
            out_data_next[dfdt_pkg::OUT_DB_LSB +: dfdt_pkg::DEP_W]      = db;
            out_data_next[dfdt_pkg::OUT_DEPTH_LSB +: dfdt_pkg::DEPTH_W] = depth;
        end
    end

    dfdt_reg_table #(
        .NUM_REGS (NUM_REGS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_src_a (in_item.src_a),
        .rd_src_b (in_item.src_b),
        .lk_first (s1_item_reg.first),
        .lk_src_a (s1_item_reg.src_a),
        .lk_src_b (s1_item_reg.src_b),
        .wr       (wr),
        .rd_a     (rd_a),
        .rd_b     (rd_b),
        .hit_a    (hit_a),
        .hit_b    (hit_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            pd_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_next;
                pd_reg        <= pd_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
            out_ovf_reg  <= ovf;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/dfdt_reg_table.sv =====
// ----------------------------------------------------------------------------
// Dataflow depth tracker register table
// Last-writer memory with two registered read ports, write bypass and
// per-register valid bits that a new program clears at once.
// ----------------------------------------------------------------------------
`default_nettype none

module dfdt_reg_table #(
    parameter int NUM_REGS = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [dfdt_pkg::REG_W-1:0] rd_src_a,
    input  wire logic [dfdt_pkg::REG_W-1:0] rd_src_b,
    input  wire logic                      lk_first,
    input  wire logic [dfdt_pkg::REG_W-1:0] lk_src_a,
    input  wire logic [dfdt_pkg::REG_W-1:0] lk_src_b,
    input  wire dfdt_pkg::tbl_wr_t         wr,
    output dfdt_pkg::entry_t               rd_a,
    output dfdt_pkg::entry_t               rd_b,
    output logic                           hit_a,
    output logic                           hit_b
);

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    dfdt_pkg::entry_t mem [NUM_REGS];
    dfdt_pkg::entry_t rd_a_reg;
    dfdt_pkg::entry_t rd_b_reg;
    logic [NUM_REGS-1:0] valid_reg;
    logic [NUM_REGS-1:0] valid_next;

    logic [8:0]    wr_w, rda_w, rdb_w, lka_w, lkb_w;
    logic          wr_ok, lka_ok, lkb_ok;
    logic          fwd_a, fwd_b;
    logic [AW-1:0] wr_addr, rda_addr, rdb_addr, lka_addr, lkb_addr;

    always_comb
    begin
        wr_w  = 9'(wr.dest);
        rda_w = 9'(rd_src_a);
        rdb_w = 9'(rd_src_b);
        lka_w = 9'(lk_src_a);
        lkb_w = 9'(lk_src_b);
        wr_addr  = wr_w[AW-1:0];
        rda_addr = rda_w[AW-1:0];
        rdb_addr = rdb_w[AW-1:0];
        lka_addr = lka_w[AW-1:0];
        lkb_addr = lkb_w[AW-1:0];
        wr_ok  = wr.en && (wr_w < 9'(NUM_REGS));
        lka_ok = lka_w < 9'(NUM_REGS);
        lkb_ok = lkb_w < 9'(NUM_REGS);
        fwd_a  = wr_ok && (rd_src_a == wr.dest);
        fwd_b  = wr_ok && (rd_src_b == wr.dest);
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_a_reg <= fwd_a ? wr.data : mem[rda_addr];
            rd_b_reg <= fwd_b ? wr.data : mem[rdb_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.clear)
        begin
            valid_next = '0;
        end
        if (wr_ok)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rd_a  = rd_a_reg;
    assign rd_b  = rd_b_reg;
    assign hit_a = !lk_first && lka_ok && valid_reg[lka_addr];
    assign hit_b = !lk_first && lkb_ok && valid_reg[lkb_addr];

endmodule

`default_nettype wire

// ===== rtl/dfdt_checker.sv =====
// ----------------------------------------------------------------------------
// Dataflow depth tracker checker
// Port-level checks on the tracker's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dataflow_depth_tracker_macros.svh"

module dfdt_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [dfdt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input wire logic                               m_axis_tuser
);

    `DFDT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `DFDT_ASSERT_SAME(a_ovf_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[dfdt_pkg::OUT_PROG_LSB-1:0] == '0)
    `DFDT_ASSERT_SAME(a_depth_order, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[dfdt_pkg::OUT_DEPTH_LSB +: dfdt_pkg::DEPTH_W] <= m_axis_tdata[dfdt_pkg::OUT_PROG_LSB +: dfdt_pkg::DEPTH_W])
    `DFDT_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

endmodule

bind dataflow_depth_tracker dfdt_checker u_dfdt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== verif/tb_dataflow_depth_tracker.sv =====
// ----------------------------------------------------------------------------
// Dataflow depth tracker testbench
// Streams instruction traces into the tracker and checks every result, field
// by field, against a predictor that keeps its own last-writer tables.
// A directed table comes first, then random programs under several latency
// settings with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dataflow_depth_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRACK_REGS  = 32;
    localparam int INST_BOUND  = 4096;
    localparam int LAT_COUNT   = 8;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 285;
    localparam int CYCLE_LIMIT = 600000;

    typedef enum logic [dfdt_pkg::CFG_IDX_W-1:0] {
        LAT_OP0, LAT_OP1, LAT_OP2, LAT_OP3, LAT_OP4, LAT_OP5, LAT_OP6, LAT_OP7
    } lat_reg_e;

    typedef enum logic [dfdt_pkg::OP_W-1:0] {
        OP_0, OP_1, OP_2, OP_3, OP_4, OP_5, OP_6, OP_7
    } op_e;

    typedef struct packed {
        logic [dfdt_pkg::IDX_W-1:0]   index;
        logic [dfdt_pkg::DEP_W-1:0]   dep_a;
        logic [dfdt_pkg::DEP_W-1:0]   dep_b;
        logic [dfdt_pkg::DEPTH_W-1:0] depth;
        logic [dfdt_pkg::DEPTH_W-1:0] prog;
        logic                         overflow;
    } depth_result_t;

    typedef struct packed {
        logic               typed;
        dfdt_pkg::in_item_t inst;
        depth_result_t      want;
    } dir_row_t;

    // All latencies are at their reset value of 1 while this table runs.
    localparam dir_row_t DIRECTED [13] = '{
        '{1'b1, '{1'b1, OP_0, 5'd0,  5'd0,  5'd0},
              '{12'd0, dfdt_pkg::DEP_ENTRY, dfdt_pkg::DEP_ENTRY, 20'd0, 20'd1, 1'b0}},
        '{1'b1, '{1'b0, OP_7, 5'd31, 5'd0,  5'd0},
              '{12'd1, 13'd0, 13'd0, 20'd1, 20'd2, 1'b0}},
        '{1'b1, '{1'b0, OP_3, 5'd5,  5'd31, 5'd31},
              '{12'd2, 13'd1, 13'd1, 20'd2, 20'd3, 1'b0}},
        '{1'b1, '{1'b0, OP_1, 5'd6,  5'd7,  5'd8},
              '{12'd3, dfdt_pkg::DEP_ENTRY, dfdt_pkg::DEP_ENTRY, 20'd0, 20'd3, 1'b0}},
        '{1'b0, '{1'b0, OP_2, 5'd31, 5'd5,  5'd6},  '0},
        '{1'b0, '{1'b0, OP_4, 5'd0,  5'd31, 5'd0},  '0},
        '{1'b0, '{1'b0, OP_5, 5'd7,  5'd21, 5'd10}, '0},
        '{1'b0, '{1'b0, OP_6, 5'd10, 5'd10, 5'd10}, '0},
        '{1'b0, '{1'b0, OP_7, 5'd21, 5'd7,  5'd31}, '0},
        '{1'b1, '{1'b1, OP_6, 5'd31, 5'd31, 5'd0},
              '{12'd0, dfdt_pkg::DEP_ENTRY, dfdt_pkg::DEP_ENTRY, 20'd0, 20'd1, 1'b0}},
        '{1'b1, '{1'b0, OP_0, 5'd31, 5'd31, 5'd31},
              '{12'd1, 13'd0, 13'd0, 20'd1, 20'd2, 1'b0}},
        '{1'b0, '{1'b0, OP_1, 5'd0,  5'd0,  5'd31}, '0},
        '{1'b1, '{1'b1, OP_2, 5'd0,  5'd31, 5'd31},
              '{12'd0, dfdt_pkg::DEP_ENTRY, dfdt_pkg::DEP_ENTRY, 20'd0, 20'd1, 1'b0}}
    };

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [dfdt_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [dfdt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             cfg_we;
    logic [dfdt_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [dfdt_pkg::LAT_W-1:0]       cfg_data;

    dataflow_depth_tracker uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    logic [dfdt_pkg::IDX_W-1:0]   last_writer [TRACK_REGS];
    bit                           has_writer  [TRACK_REGS];
    logic [dfdt_pkg::DEPTH_W-1:0] done_time   [TRACK_REGS];
    logic [dfdt_pkg::LAT_W-1:0]   op_latency  [LAT_COUNT];
    int unsigned                  seq_count;
    logic [dfdt_pkg::DEPTH_W-1:0] crit_depth;

    depth_result_t pending_results [$];
    int unsigned   fail_count;
    int unsigned   cycle_count;
    bit            gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int unsigned pick_wait();
        return gaps_on ? $urandom_range(0, 4) : 0;
    endfunction

    function automatic logic [dfdt_pkg::REG_W-1:0] rand_reg();
        // Mostly a small register set, so that dependency chains form.
        if ($urandom_range(0, 3) == 0)
            return dfdt_pkg::REG_W'($urandom_range(0, TRACK_REGS - 1));
        return dfdt_pkg::REG_W'($urandom_range(0, 7));
    endfunction

    function automatic dfdt_pkg::in_item_t rand_inst();
        dfdt_pkg::in_item_t it;
        it.first  = ($urandom_range(0, 63) == 0);
        it.opcode = op_e'($urandom_range(0, LAT_COUNT - 1));
        it.dest   = rand_reg();
        it.src_a  = rand_reg();
        it.src_b  = rand_reg();
        return it;
    endfunction

    function automatic depth_result_t track_instruction(dfdt_pkg::in_item_t it);
        depth_result_t                r;
        logic [dfdt_pkg::DEPTH_W-1:0] ta;
        logic [dfdt_pkg::DEPTH_W-1:0] tb;
        logic [dfdt_pkg::DEPTH_W:0]   fin;
        if (it.first)
        begin
            for (int i = 0; i < TRACK_REGS; i++)
            begin
                has_writer[i] = 1'b0;
                done_time[i]  = '0;
            end
            seq_count  = 0;
            crit_depth = '0;
        end
        r = '0;
        if (seq_count >= INST_BOUND)
        begin
            r.prog     = crit_depth;
            r.overflow = 1'b1;
            return r;
        end
        r.dep_a = has_writer[it.src_a] ? {1'b0, last_writer[it.src_a]} : dfdt_pkg::DEP_ENTRY;
        ta      = has_writer[it.src_a] ? done_time[it.src_a] : '0;
        r.dep_b = has_writer[it.src_b] ? {1'b0, last_writer[it.src_b]} : dfdt_pkg::DEP_ENTRY;
        tb      = has_writer[it.src_b] ? done_time[it.src_b] : '0;
        r.depth = (ta >= tb) ? ta : tb;
        fin = {1'b0, r.depth} + (dfdt_pkg::DEPTH_W + 1)'(op_latency[it.opcode]);
        if (fin > {1'b0, dfdt_pkg::DEPTH_MAX})
            fin = {1'b0, dfdt_pkg::DEPTH_MAX};
        last_writer[it.dest] = dfdt_pkg::IDX_W'(seq_count);
        has_writer[it.dest]  = 1'b1;
        done_time[it.dest]   = fin[dfdt_pkg::DEPTH_W-1:0];
        if (fin[dfdt_pkg::DEPTH_W-1:0] > crit_depth)
            crit_depth = fin[dfdt_pkg::DEPTH_W-1:0];
        r.prog  = crit_depth;
        r.index = dfdt_pkg::IDX_W'(seq_count);
        seq_count++;
        return r;
    endfunction

    task automatic send_inst(dfdt_pkg::in_item_t it, logic typed, depth_result_t typed_want);
        int unsigned   gap;
        depth_result_t want;
        gap = pick_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  = dfdt_pkg::IN_TDATA_W'({it.src_b, it.src_a, it.dest, it.opcode});
        s_axis_tuser  = it.first;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = track_instruction(it);
        pending_results.insert(pending_results.size(), typed ? typed_want : want);
    endtask

    task automatic settle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [dfdt_pkg::LAT_W-1:0] phase_latency(int phase, int op);
        case (phase)
            0:       return '0;
            1:       return '1;
            3:       return (op % 2 == 0) ? '0 : '1;
            default: return dfdt_pkg::LAT_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic load_latencies(int phase);
        for (int i = 0; i < LAT_COUNT; i++)
        begin
            @(negedge clk);
            cfg_we        = 1'b1;
            cfg_index     = lat_reg_e'(i);
            cfg_data      = phase_latency(phase, i);
            op_latency[i] = cfg_data;
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin : result_sink
        depth_result_t got;
        depth_result_t want;
        int unsigned   hold;
        hold          = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_axis_tready = 1'b0;
                hold--;
            end
            else
                m_axis_tready = 1'b1;
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.index    = m_axis_tdata[dfdt_pkg::OUT_IDX_LSB +: dfdt_pkg::IDX_W];
                got.dep_a    = m_axis_tdata[dfdt_pkg::OUT_DA_LSB +: dfdt_pkg::DEP_W];
                got.dep_b    = m_axis_tdata[dfdt_pkg::OUT_DB_LSB +: dfdt_pkg::DEP_W];
                got.depth    = m_axis_tdata[dfdt_pkg::OUT_DEPTH_LSB +: dfdt_pkg::DEPTH_W];
                got.prog     = m_axis_tdata[dfdt_pkg::OUT_PROG_LSB +: dfdt_pkg::DEPTH_W];
                got.overflow = m_axis_tuser;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unrequested result: index %0d", got.index);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("Mismatch: expected idx %0d a %0d b %0d depth %0d prog %0d ovf %0d",
                                     want.index, $signed(want.dep_a), $signed(want.dep_b),
                                     want.depth, want.prog, want.overflow);
                            $display("          got idx %0d a %0d b %0d depth %0d prog %0d ovf %0d",
                                     got.index, $signed(got.dep_a), $signed(got.dep_b),
                                     got.depth, got.prog, got.overflow);
                        end
                    end
                end
                hold = pick_wait();
            end
        end
    end

    initial
    begin : stimulus
        dfdt_pkg::in_item_t it;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        gaps_on       = 1'b1;
        seq_count     = 0;
        crit_depth    = '0;
        for (int i = 0; i < TRACK_REGS; i++)
        begin
            has_writer[i]  = 1'b0;
            done_time[i]   = '0;
            last_writer[i] = '0;
        end
        for (int i = 0; i < LAT_COUNT; i++)
            op_latency[i] = dfdt_pkg::LAT_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[r])
            send_inst(DIRECTED[r].inst, DIRECTED[r].typed, DIRECTED[r].want);
        settle();

        // Phases after the first continue the running program, so stored finish
        // times keep the latency that was in force when they were written.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            load_latencies(ph);
            gaps_on = (ph != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it = rand_inst();
                send_inst(it, 1'b0, '0);
            end
            settle();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
